FILE: rtl/core/sdlc_pkg.sv
// Shared constants, command codes, register indexes and state codes of the light controller.
`timescale 1ns / 1ps

package sdlc_pkg;

  // Width of the lux fields and of the lux registers.
  localparam int LUX_BITS   = 16;
  localparam int LEVEL_BITS = 8;
  localparam int HOUR_BITS  = 5;
  localparam int REQ_BITS   = 10;
  localparam int CMD_BITS   = 2;
  localparam int IDX_BITS   = 3;
  // Configuration data is as wide as the widest register.
  localparam int CFG_BITS   = (LUX_BITS > LEVEL_BITS) ? LUX_BITS : LEVEL_BITS;
  // Product of brightness and lux difference; also holds remainder and quotient.
  localparam int ACC_BITS   = LEVEL_BITS + LUX_BITS;
  localparam int STEP_BITS  = $clog2(LEVEL_BITS);

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX     = LEVEL_BITS'(255);
  localparam logic [LEVEL_BITS-1:0] PIN_THRESHOLD = LEVEL_BITS'(128);
  localparam logic [STEP_BITS-1:0]  LAST_STEP     = STEP_BITS'(LEVEL_BITS - 1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_UPDATE   = 2'd0,
    CMD_OVERRIDE = 2'd1,
    CMD_CANCEL   = 2'd2,
    CMD_DIRECT   = 2'd3
  } cmd_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_AUTO_MODE   = 3'd0,
    REG_SENSOR_MODE = 3'd1,
    REG_START_HOUR  = 3'd2,
    REG_END_HOUR    = 3'd3,
    REG_SET_BRIGHT  = 3'd4,
    REG_MIN_LUX     = 3'd5,
    REG_MAX_LUX     = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

endpackage

FILE: rtl/core/scheduled_dimming_light_controller_core.sv
// Top level of the scheduled dimming light controller with its serial dimming datapath.
`timescale 1ns / 1ps

// Usage:
// Items arrive on the input channel (in_valid/in_ready) and each one produces exactly
// one result item on the output channel (out_valid/out_ready). An item carries a
// command: update, set override, cancel override or direct brightness set.
// Configuration registers are written through cfg_write/cfg_index/cfg_data; index 7
// is ignored. The user must write them only while the block is idle; the block itself
// does not enforce this. An item that needs no dimming ratio goes from acceptance to
// result through capture, decision and finish. An evaluation in auto and sensor mode
// inside the window, with lux strictly between min and max, runs the ratio serially:
// shift-and-add multiplication, one brightness bit per cycle, then restoring division,
// one quotient bit per cycle. Both phases share the single accumulator; one item is
// processed at a time.
// The result sits in an output register, so the next item is accepted as soon as
// the datapath is idle, even while the receiver stalls. If a finished result finds
// the output register still full, the block holds it until the register drains;
// lamp state is committed only when the result is loaded.
// Reset (rst, synchronous) clears the configuration registers, the lamp level, the
// override flag, the sequencer state and out_valid.
module scheduled_dimming_light_controller_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          cfg_write,
  input  logic [sdlc_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [sdlc_pkg::CFG_BITS-1:0] cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sdlc_pkg::CMD_BITS-1:0] command,
  input  logic [sdlc_pkg::HOUR_BITS-1:0] hour_now,
  input  logic                          time_valid,
  input  logic [sdlc_pkg::LUX_BITS-1:0] ambient_lux,
  input  logic                          override_on,
  input  logic signed [sdlc_pkg::REQ_BITS-1:0] requested_level,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdlc_pkg::LEVEL_BITS-1:0] brightness,
  output logic                          lamp_on,
  output logic                          pin_level,
  output logic                          override_active,
  output logic                          changed
);
  import sdlc_pkg::*;

  // Configuration registers.
  logic                   auto_mode;
  logic                   sensor_mode;
  logic [HOUR_BITS-1:0]   start_hour;
  logic [HOUR_BITS-1:0]   end_hour;
  logic [LEVEL_BITS-1:0]  set_brightness;
  logic [LUX_BITS-1:0]    min_lux;
  logic [LUX_BITS-1:0]    max_lux;

  // Lamp state.
  logic [LEVEL_BITS-1:0]  level_reg;
  logic                   manual_flag;

  // Captured item.
  cmd_t                   cmd;
  logic [HOUR_BITS-1:0]   hour;
  logic                   tvalid;
  logic [LUX_BITS-1:0]    lux;
  logic                   ovr;
  logic [REQ_BITS-1:0]    req;

  // Pending result and serial datapath.
  state_t                 state;
  logic [LEVEL_BITS-1:0]  target;
  logic                   write_pend;
  logic [ACC_BITS-1:0]    acc;
  logic [LEVEL_BITS-1:0]  mplier;
  logic [LUX_BITS-1:0]    diff;
  logic [LUX_BITS-1:0]    den;
  logic [STEP_BITS-1:0]   step;

  // Decision logic for the captured item.
  logic                   in_window;
  logic                   eval_en;
  logic                   need_div;
  logic [LEVEL_BITS-1:0]  clamped;
  logic [LEVEL_BITS-1:0]  eval_target;
  logic                   manual_next;

  // Serial step logic.
  logic [ACC_BITS-1:0]    mul_next;
  logic [LUX_BITS:0]      div_trial;
  logic                   div_fit;
  logic [ACC_BITS-1:0]    div_next;

  logic                   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Saturate the signed request to the brightness range.
  always_comb begin
    if (req[REQ_BITS-1]) begin
      clamped = '0;
    end else if (req[REQ_BITS-2:0] > (REQ_BITS-1)'(LEVEL_MAX)) begin
      clamped = LEVEL_MAX;
    end else begin
      clamped = req[LEVEL_BITS-1:0];
    end
  end

  // A window whose start is not below its end wraps past midnight (or covers all day).
  always_comb begin
    if (start_hour < end_hour) begin
      in_window = (hour >= start_hour) && (hour < end_hour);
    end else begin
      in_window = (hour >= start_hour) || (hour < end_hour);
    end
  end

  always_comb begin
    need_div    = 1'b0;
    eval_target = '0;
    if (auto_mode && in_window) begin
      if (!sensor_mode || (lux <= min_lux)) begin
        eval_target = set_brightness;
      end else if (lux >= max_lux) begin
        eval_target = '0;
      end else begin
        need_div = 1'b1;
      end
    end
  end

  // Work out whether an evaluation runs and what becomes of the override flag.
  always_comb begin
    eval_en     = 1'b0;
    manual_next = manual_flag;
    unique case (cmd)
      CMD_UPDATE: begin
        eval_en = !manual_flag && tvalid;
      end
      CMD_OVERRIDE: begin
        manual_next = ovr;
        eval_en     = !ovr && tvalid;
      end
      CMD_CANCEL: begin
        manual_next = 1'b0;
        eval_en     = manual_flag && tvalid;
      end
      CMD_DIRECT: begin
        eval_en = 1'b0;
      end
      default: begin
        eval_en = 1'b0;
      end
    endcase
  end

  // Multiplication: brightness bits MSB first, add the lux difference when set.
  assign mul_next = {acc[ACC_BITS-2:0], 1'b0}
                  + (mplier[LEVEL_BITS-1] ? ACC_BITS'(diff) : '0);

  // Restoring division: upper part is the remainder, lower part collects quotient bits.
  assign div_trial = {acc[ACC_BITS-1:LEVEL_BITS], acc[LEVEL_BITS-1]};
  assign div_fit   = div_trial >= {1'b0, den};
  always_comb begin
    if (div_fit) begin
      div_next = {LUX_BITS'(div_trial - {1'b0, den}), acc[LEVEL_BITS-2:0], 1'b1};
    end else begin
      div_next = {div_trial[LUX_BITS-1:0], acc[LEVEL_BITS-2:0], 1'b0};
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode      <= 1'b0;
      sensor_mode    <= 1'b0;
      start_hour     <= '0;
      end_hour       <= '0;
      set_brightness <= '0;
      min_lux        <= '0;
      max_lux        <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_AUTO_MODE:   auto_mode      <= cfg_data[0];
        REG_SENSOR_MODE: sensor_mode    <= cfg_data[0];
        REG_START_HOUR:  start_hour     <= cfg_data[HOUR_BITS-1:0];
        REG_END_HOUR:    end_hour       <= cfg_data[HOUR_BITS-1:0];
        REG_SET_BRIGHT:  set_brightness <= cfg_data[LEVEL_BITS-1:0];
        REG_MIN_LUX:     min_lux        <= cfg_data[LUX_BITS-1:0];
        REG_MAX_LUX:     max_lux        <= cfg_data[LUX_BITS-1:0];
        REG_UNUSED:      ;
        default:         ;
      endcase
    end
  end

  // Item capture (payload registers, no reset needed).
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd    <= cmd_t'(command);
      hour   <= hour_now;
      tvalid <= time_valid;
      lux    <= ambient_lux;
      ovr    <= override_on;
      req    <= requested_level;
    end
  end

  // Sequencer and serial datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      level_reg   <= '0;
      manual_flag <= 1'b0;
      write_pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          manual_flag <= manual_next;
          if ((cmd == CMD_DIRECT) || ((cmd == CMD_OVERRIDE) && ovr)) begin
            target     <= clamped;
            write_pend <= 1'b1;
            state      <= S_FINISH;
          end else if (eval_en && need_div) begin
            acc    <= '0;
            mplier <= set_brightness;
            diff   <= max_lux - lux;
            den    <= max_lux - min_lux;
            step   <= '0;
            state  <= S_MUL;
          end else begin
            target     <= eval_target;
            write_pend <= eval_en && (eval_target != level_reg);
            state      <= S_FINISH;
          end
        end
        S_MUL: begin
          acc    <= mul_next;
          mplier <= {mplier[LEVEL_BITS-2:0], 1'b0};
          step   <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          acc  <= div_next;
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            target     <= div_next[LEVEL_BITS-1:0];
            write_pend <= div_next[LEVEL_BITS-1:0] != level_reg;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if (write_pend) begin
              level_reg <= target;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output valid: set when a result is loaded, cleared when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register, loaded together with the committed lamp state.
  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      brightness      <= write_pend ? target : level_reg;
      lamp_on         <= write_pend ? (target != '0) : (level_reg != '0);
      pin_level       <= write_pend ? (target > PIN_THRESHOLD) : (level_reg > PIN_THRESHOLD);
      override_active <= manual_flag;
      changed         <= write_pend;
    end
  end

endmodule

FILE: test/scheduled_dimming_light_controller_core_tb.sv
// Self-checking testbench of the scheduled dimming light controller core.
`timescale 1ns / 1ps

module scheduled_dimming_light_controller_core_tb;
  import sdlc_pkg::*;

  // One command item as the driver presents it on the input channel.
  typedef struct packed {
    cmd_t                 cmd;
    logic [HOUR_BITS-1:0] hour;
    logic                 tv;
    logic [LUX_BITS-1:0]  lux;
    logic                 ovr;
    logic [REQ_BITS-1:0]  req;
  } lamp_cmd_t;

  // Lamp state reported after one item.
  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  lit;
    logic                  pin;
    logic                  manual;
    logic                  changed;
  } lamp_res_t;

  // The scheduler settings, kept at the widths of the registers.
  typedef struct packed {
    logic                  auto_en;
    logic                  sensor_en;
    logic [HOUR_BITS-1:0]  win_start;
    logic [HOUR_BITS-1:0]  win_stop;
    logic [LEVEL_BITS-1:0] full_level;
    logic [LUX_BITS-1:0]   lux_lo;
    logic [LUX_BITS-1:0]   lux_hi;
  } lamp_cfg_t;

  // One row of the directed table. Rows marked typed carry a hand-written lamp
  // state; all other rows are checked against the predictor.
  typedef struct packed {
    lamp_cmd_t item;
    logic      typed;
    lamp_res_t res;
  } dir_row_t;

  // Rows before this index run with the reset settings, the rest with the directed settings.
  localparam int CFG_SPLIT    = 17;
  localparam int BLOCKS       = 5;
  localparam int BLOCK_ITEMS  = 100;
  localparam int SETTLE_TICKS = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_BITS-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_BITS-1:0]   command = '0;
  logic [HOUR_BITS-1:0]  hour_now = '0;
  logic                  time_valid = 1'b0;
  logic [LUX_BITS-1:0]   ambient_lux = '0;
  logic                  override_on = 1'b0;
  logic signed [REQ_BITS-1:0] requested_level = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LEVEL_BITS-1:0] brightness;
  logic                  lamp_on;
  logic                  pin_level;
  logic                  override_active;
  logic                  changed;

  // Predictor state: its own copy of the settings, the lamp level and the
  // manual-hold flag. The on flag is simply the level being nonzero.
  lamp_cfg_t             sched_cfg = '0;
  logic [LEVEL_BITS-1:0] lamp_level = '0;
  logic                  manual_hold = 1'b0;

  lamp_res_t pending_lamp_q[$];
  dir_row_t  dir_rows[$];
  lamp_res_t want_lamp;
  int        errors = 0;
  int        send_idle_pct = 31;
  int        recv_idle_pct = 52;

  scheduled_dimming_light_controller_core u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .hour_now        (hour_now),
    .time_valid      (time_valid),
    .ambient_lux     (ambient_lux),
    .override_on     (override_on),
    .requested_level (requested_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .brightness      (brightness),
    .lamp_on         (lamp_on),
    .pin_level       (pin_level),
    .override_active (override_active),
    .changed         (changed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scheduler evaluation. It does nothing while the manual hold is set or the
  // time is unknown. Otherwise the goal level is zero with auto mode off or outside
  // the window; the window wraps past midnight when start is not below stop, which
  // also makes start equal to stop an all-day window. Inside the window sensor mode
  // dims the set level linearly between the two lux thresholds, rounding down. The
  // level is only rewritten when the goal differs from it.
  function automatic logic run_schedule(lamp_cmd_t c);
    logic [LEVEL_BITS-1:0]          goal;
    logic                           in_window;
    logic [LEVEL_BITS+LUX_BITS-1:0] num;
    logic [LUX_BITS-1:0]            den;
    goal = '0;
    if (manual_hold || !c.tv) return 1'b0;
    if (sched_cfg.auto_en) begin
      if (sched_cfg.win_start < sched_cfg.win_stop) begin
        in_window = c.hour >= sched_cfg.win_start && c.hour < sched_cfg.win_stop;
      end else begin
        in_window = c.hour >= sched_cfg.win_start || c.hour < sched_cfg.win_stop;
      end
      if (in_window) begin
        if (!sched_cfg.sensor_en || c.lux <= sched_cfg.lux_lo) begin
          goal = sched_cfg.full_level;
        end else if (c.lux >= sched_cfg.lux_hi) begin
          goal = '0;
        end else begin
          // Here lux_lo < lux < lux_hi, so the divisor is never zero.
          num  = sched_cfg.full_level * (sched_cfg.lux_hi - c.lux);
          den  = sched_cfg.lux_hi - sched_cfg.lux_lo;
          goal = LEVEL_BITS'(num / den);
        end
      end
    end
    if (goal != lamp_level) begin
      lamp_level = goal;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one item to the predictor state and returns the lamp state after it.
  function automatic lamp_res_t predict_lamp(lamp_cmd_t c);
    lamp_res_t             r;
    logic [LEVEL_BITS-1:0] clamped;
    logic                  wrote;
    int                    req_val;
    wrote   = 1'b0;
    req_val = $signed(c.req);
    // The requested level saturates to the 0..255 range of the lamp.
    if (req_val < 0) clamped = '0;
    else if (req_val > int'(LEVEL_MAX)) clamped = LEVEL_MAX;
    else clamped = LEVEL_BITS'(req_val);
    case (c.cmd)
      CMD_UPDATE: begin
        wrote = run_schedule(c);
      end
      CMD_OVERRIDE: begin
        // Taking manual control always rewrites the level, even an equal one;
        // releasing it hands straight back to the scheduler.
        manual_hold = c.ovr;
        if (c.ovr) begin
          lamp_level = clamped;
          wrote      = 1'b1;
        end else begin
          wrote = run_schedule(c);
        end
      end
      CMD_CANCEL: begin
        // A cancel without a manual hold is a no-op.
        if (manual_hold) begin
          manual_hold = 1'b0;
          wrote       = run_schedule(c);
        end
      end
      default: begin
        // A direct set leaves the manual hold as it is.
        lamp_level = clamped;
        wrote      = 1'b1;
      end
    endcase
    r.level   = lamp_level;
    r.lit     = lamp_level != '0;
    r.pin     = lamp_level > PIN_THRESHOLD;
    r.manual  = manual_hold;
    r.changed = wrote;
    return r;
  endfunction

  function automatic lamp_res_t lamp(int lvl, bit lit, bit pin, bit man, bit chg);
    lamp_res_t r;
    r = {LEVEL_BITS'(lvl), lit, pin, man, chg};
    return r;
  endfunction

  function automatic void add_row(cmd_t cmd, int hour, bit tv, int lux, bit ovr, int req,
                                  bit typed, lamp_res_t res);
    dir_row_t row;
    row.item.cmd  = cmd;
    row.item.hour = HOUR_BITS'(hour);
    row.item.tv   = tv;
    row.item.lux  = LUX_BITS'(lux);
    row.item.ovr  = ovr;
    row.item.req  = REQ_BITS'(req);
    row.typed     = typed;
    row.res       = res;
    dir_rows.push_back(row);
  endfunction

  function automatic lamp_cfg_t make_settings(bit a, bit s, int st, int sp, int fl,
                                              int lo, int hi);
    lamp_cfg_t c;
    c.auto_en    = a;
    c.sensor_en  = s;
    c.win_start  = HOUR_BITS'(st);
    c.win_stop   = HOUR_BITS'(sp);
    c.full_level = LEVEL_BITS'(fl);
    c.lux_lo     = LUX_BITS'(lo);
    c.lux_hi     = LUX_BITS'(hi);
    return c;
  endfunction

  // Settings for random block k. A handful of blocks use fixed corner settings;
  // the rest draw a random window and a random, properly ordered lux span.
  function automatic lamp_cfg_t pick_settings(int k);
    lamp_cfg_t s;
    int        lo;
    lo = $urandom_range(60000);
    s  = make_settings($urandom_range(9) < 8, $urandom_range(9) < 7, $urandom_range(23),
                       $urandom_range(23), $urandom_range(255), lo,
                       lo + $urandom_range(65535 - lo, 1));
    case (k)
      0:  s = make_settings(1, 1, 23, 23, 255, 65535, 65535);
      1:  s = make_settings(1, 1, 0, 0, 255, 0, 65535);
      5:  s.sensor_en = 1'b0;
      7:  s.auto_en = 1'b0;
      10: s = make_settings(1, 1, 20, 4, $urandom_range(255), 50000, 1000);
      12: s = make_settings(1, 1, 0, 1, 1, 0, 2);
      default: ;
    endcase
    return s;
  endfunction

  // A random item. Lux is steered toward the thresholds and the dimming span
  // so that every branch of the scheduler gets exercised.
  function automatic lamp_cmd_t rand_lamp_cmd();
    lamp_cmd_t c;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 55) c.cmd = CMD_UPDATE;
    else if (pick < 70) c.cmd = CMD_OVERRIDE;
    else if (pick < 85) c.cmd = CMD_CANCEL;
    else c.cmd = CMD_DIRECT;
    c.hour = ($urandom_range(9) == 0) ? HOUR_BITS'($urandom_range(31, 24))
                                      : HOUR_BITS'($urandom_range(23));
    c.tv   = $urandom_range(9) != 0;
    c.ovr  = $urandom_range(9) < 7;
    c.req  = $urandom_range(1) ? REQ_BITS'($urandom_range(255)) : REQ_BITS'($urandom);
    case ($urandom_range(9))
      0: c.lux = '0;
      1: c.lux = '1;
      2: c.lux = sched_cfg.lux_lo;
      3: c.lux = sched_cfg.lux_hi;
      4: c.lux = sched_cfg.lux_lo + 1'b1;
      5: c.lux = sched_cfg.lux_hi - 1'b1;
      6: c.lux = LUX_BITS'($urandom);
      default: begin
        if (sched_cfg.lux_hi > sched_cfg.lux_lo + 1) begin
          c.lux = LUX_BITS'($urandom_range(int'(sched_cfg.lux_hi) - 1,
                                           int'(sched_cfg.lux_lo) + 1));
        end else begin
          c.lux = LUX_BITS'($urandom);
        end
      end
    endcase
    return c;
  endfunction

  // One register write. The caller lowers cfg_write once the whole batch is in,
  // so back-to-back writes keep the enable high without a glitch.
  task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_AUTO_MODE:   sched_cfg.auto_en    = data[0];
      REG_SENSOR_MODE: sched_cfg.sensor_en  = data[0];
      REG_START_HOUR:  sched_cfg.win_start  = data[HOUR_BITS-1:0];
      REG_END_HOUR:    sched_cfg.win_stop   = data[HOUR_BITS-1:0];
      REG_SET_BRIGHT:  sched_cfg.full_level = data[LEVEL_BITS-1:0];
      REG_MIN_LUX:     sched_cfg.lux_lo     = data[LUX_BITS-1:0];
      REG_MAX_LUX:     sched_cfg.lux_hi     = data[LUX_BITS-1:0];
      default: ;
    endcase
  endtask

  // Writes every register. Unused upper data bits of the narrow registers carry
  // random junk, which must be ignored, and the spare index is hit as well.
  task automatic apply_settings(lamp_cfg_t s);
    logic [CFG_BITS-1:0] junk;
    junk = CFG_BITS'($urandom);
    write_reg(REG_AUTO_MODE,   {junk[CFG_BITS-1:1], s.auto_en});
    write_reg(REG_SENSOR_MODE, {junk[CFG_BITS-1:1], s.sensor_en});
    write_reg(REG_START_HOUR,  {junk[CFG_BITS-1:HOUR_BITS], s.win_start});
    write_reg(REG_END_HOUR,    {junk[CFG_BITS-1:HOUR_BITS], s.win_stop});
    write_reg(REG_SET_BRIGHT,  {junk[CFG_BITS-1:LEVEL_BITS], s.full_level});
    write_reg(REG_MIN_LUX,     s.lux_lo);
    write_reg(REG_MAX_LUX,     s.lux_hi);
    write_reg(REG_UNUSED,      junk);
    cfg_write <= 1'b0;
  endtask

  // Presents one item, waits for the handshake and records what the lamp state
  // must be afterwards. Idle gaps come before the item, never mid-handshake, so
  // valid and payload stay put until the item is taken.
  task automatic send_lamp_cmd(lamp_cmd_t c, logic typed, lamp_res_t typed_res);
    lamp_res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= c.cmd;
    hour_now        <= c.hour;
    time_valid      <= c.tv;
    ambient_lux     <= c.lux;
    override_on     <= c.ovr;
    requested_level <= c.req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_lamp(c);
    pending_lamp_q.push_back(typed ? typed_res : predicted);
  endtask

  // Waits until every recorded item has come back out; the core is then idle.
  task automatic wait_drained();
    while (pending_lamp_q.size() != 0) @(posedge clk);
  endtask

  // Result side: random back-pressure, and a field-by-field check of every
  // accepted result against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_lamp_q.size() == 0) begin
        $error("result item with no item outstanding: brightness %0d", brightness);
        errors++;
      end else begin
        want_lamp = pending_lamp_q.pop_front();
        if (brightness !== want_lamp.level) begin
          $error("brightness: expected %0d, got %0d", want_lamp.level, brightness);
          errors++;
        end
        if (lamp_on !== want_lamp.lit) begin
          $error("lamp_on: expected %0b, got %0b", want_lamp.lit, lamp_on);
          errors++;
        end
        if (pin_level !== want_lamp.pin) begin
          $error("pin_level: expected %0b, got %0b", want_lamp.pin, pin_level);
          errors++;
        end
        if (override_active !== want_lamp.manual) begin
          $error("override_active: expected %0b, got %0b", want_lamp.manual, override_active);
          errors++;
        end
        if (changed !== want_lamp.changed) begin
          $error("changed: expected %0b, got %0b", want_lamp.changed, changed);
          errors++;
        end
      end
    end
    out_ready <= $urandom_range(99) >= recv_idle_pct;
  end

  // Main sequence: reset, directed table, then three random phases that differ
  // in how often each side idles, each made of several settings blocks.
  initial begin
    // With the reset settings auto mode is off, so every evaluation aims at zero
    // and each row below can be typed in by hand.
    add_row(CMD_UPDATE,   0, 1, 0,     0, 0,    1, lamp(0, 0, 0, 0, 0));
    add_row(CMD_DIRECT,   0, 1, 0,     0, 511,  1, lamp(255, 1, 1, 0, 1));
    add_row(CMD_DIRECT,   0, 1, 0,     0, -512, 1, lamp(0, 0, 0, 0, 1));
    // Pin threshold: 128 keeps the pin low, 129 drives it high.
    add_row(CMD_DIRECT,   0, 1, 0,     0, 128,  1, lamp(128, 1, 0, 0, 1));
    add_row(CMD_DIRECT,   0, 1, 0,     0, 129,  1, lamp(129, 1, 1, 0, 1));
    // An unknown time skips the update.
    add_row(CMD_UPDATE,   5, 0, 0,     0, 0,    1, lamp(129, 1, 1, 0, 0));
    add_row(CMD_UPDATE,   31, 1, 65535, 1, 0,   1, lamp(0, 0, 0, 0, 1));
    add_row(CMD_OVERRIDE, 0, 1, 0,     1, 300,  1, lamp(255, 1, 1, 1, 1));
    // Overriding with the same level still counts as a write.
    add_row(CMD_OVERRIDE, 0, 1, 0,     1, 255,  1, lamp(255, 1, 1, 1, 1));
    add_row(CMD_UPDATE,   10, 1, 0,    0, 0,    1, lamp(255, 1, 1, 1, 0));
    // A direct set under manual hold writes the level but keeps the hold.
    add_row(CMD_DIRECT,   0, 1, 0,     0, -1,   1, lamp(0, 0, 0, 1, 1));
    add_row(CMD_CANCEL,   0, 1, 0,     0, 0,    1, lamp(0, 0, 0, 0, 0));
    add_row(CMD_CANCEL,   0, 1, 0,     0, 0,    1, lamp(0, 0, 0, 0, 0));
    add_row(CMD_OVERRIDE, 0, 1, 0,     1, 40,   1, lamp(40, 1, 0, 1, 1));
    // Cancel with unknown time clears the hold but evaluates nothing.
    add_row(CMD_CANCEL,   0, 0, 0,     0, 0,    1, lamp(40, 1, 0, 0, 0));
    add_row(CMD_OVERRIDE, 0, 0, 0,     0, 300,  1, lamp(40, 1, 0, 0, 0));
    add_row(CMD_UPDATE,   0, 1, 0,     0, 0,    1, lamp(0, 0, 0, 0, 1));
    // From here the window runs 22 to 6 across midnight, set level 200, dimming
    // between 1000 and 3000 lux; these rows go through the predictor.
    add_row(CMD_UPDATE,   23, 1, 0,    0, 0,    0, '0);
    add_row(CMD_UPDATE,   5, 1, 1000,  0, 0,    0, '0);
    add_row(CMD_UPDATE,   6, 1, 0,     0, 0,    0, '0);
    add_row(CMD_UPDATE,   2, 1, 2000,  0, 0,    0, '0);
    add_row(CMD_UPDATE,   3, 1, 2999,  0, 0,    0, '0);
    add_row(CMD_UPDATE,   24, 1, 1001, 0, 0,    0, '0);
    add_row(CMD_UPDATE,   22, 1, 3000, 0, 0,    0, '0);
    add_row(CMD_OVERRIDE, 1, 1, 0,     1, 77,   0, '0);
    add_row(CMD_CANCEL,   12, 1, 0,    0, 0,    0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (i == CFG_SPLIT) begin
        in_valid <= 1'b0;
        wait_drained();
        apply_settings(make_settings(1, 1, 22, 6, 200, 1000, 3000));
      end
      send_lamp_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        // Settings change only with nothing in flight.
        in_valid <= 1'b0;
        wait_drained();
        apply_settings(pick_settings(phase * BLOCKS + blk));
        repeat (BLOCK_ITEMS) send_lamp_cmd(rand_lamp_cmd(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    // Keep running a while longer, to catch stray results.
    repeat (SETTLE_TICKS) @(posedge clk);
    if (errors == 0) begin
      $display("scheduled_dimming_light_controller_core_tb OK");
    end else begin
      $display("scheduled_dimming_light_controller_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run under the heaviest stalls.
  initial begin
    #2000000;
    $display("scheduled_dimming_light_controller_core_tb NOT OK");
    $finish;
  end

endmodule
